### hw/rtl/slj_pkg.sv
// Shared constants and types of the slot journal state log.
package slj_pkg;

  localparam int NUM_SLOTS = 64;
  localparam int ADDR_W    = $clog2(NUM_SLOTS);
  localparam int PTR_W     = $clog2(NUM_SLOTS + 1);

  localparam logic [7:0] SLOT_EMPTY     = 8'hFF;
  localparam logic [7:0] NO_RESUME_MARK = 8'hEE;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_MARK  = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_WRD   = 7'b0000100,
    ST_WCHK  = 7'b0001000,
    ST_RRD   = 7'b0010000,
    ST_RCHK  = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_e;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wdata;
  } mem_req_t;

  typedef struct packed {
    logic       valid;
    logic       resume_valid;
    logic [7:0] resume_state;
    logic       log_full;
  } result_t;

endpackage

### hw/rtl/slj_ram.sv
// Generic single-port synchronous RAM with registered read data.
module slj_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

### hw/rtl/slj_ctrl.sv
// Command sequencer: clearing pass, write-pointer scan and resume scan over the slot RAM.
module slj_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               command_i,
  input  logic [7:0]               state_value_i,
  output slj_pkg::mem_req_t        mem_req_o,
  input  logic [7:0]               mem_rdata_i,
  output slj_pkg::result_t         result_o,
  input  logic                     result_take_i
);

  localparam logic [slj_pkg::ADDR_W-1:0] LastAddr = slj_pkg::ADDR_W'(slj_pkg::NUM_SLOTS - 1);
  localparam logic [slj_pkg::PTR_W-1:0]  LastPtr  = slj_pkg::PTR_W'(slj_pkg::NUM_SLOTS - 1);
  localparam logic [slj_pkg::PTR_W-1:0]  EndPtr   = slj_pkg::PTR_W'(slj_pkg::NUM_SLOTS);

  slj_pkg::state_e                state_q, state_d;
  logic [slj_pkg::PTR_W-1:0]      wp_q, wp_d;
  logic [slj_pkg::ADDR_W-1:0]     scan_q, scan_d;
  logic [7:0]                     byte_q, byte_d;
  logic [7:0]                     last_q, last_d;
  logic                           any_q, any_d;
  slj_pkg::result_t               res_q, res_d;
  logic                           accept;

  assign in_stall_o = (state_q != slj_pkg::ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign result_o   = res_q;

  always_comb begin
    state_d         = state_q;
    wp_d            = wp_q;
    scan_d          = scan_q;
    byte_d          = byte_q;
    last_d          = last_q;
    any_d           = any_q;
    res_d           = res_q;
    mem_req_o.we    = 1'b0;
    mem_req_o.addr  = scan_q;
    mem_req_o.wdata = slj_pkg::SLOT_EMPTY;

    unique case (state_q)
      slj_pkg::ST_CLEAR: begin
        mem_req_o.we = 1'b1;
        scan_d       = scan_q + 1'b1;
        if (scan_q == LastAddr) begin
          state_d = slj_pkg::ST_IDLE;
        end
      end
      slj_pkg::ST_IDLE: begin
        if (accept) begin
          res_d   = '0;
          scan_d  = '0;
          last_d  = '0;
          any_d   = 1'b0;
          byte_d  = state_value_i;
          unique case (slj_pkg::cmd_e'(command_i))
            slj_pkg::CMD_WRITE, slj_pkg::CMD_MARK: begin
              if (slj_pkg::cmd_e'(command_i) == slj_pkg::CMD_MARK) begin
                byte_d = slj_pkg::NO_RESUME_MARK;
              end
              if (wp_q == EndPtr) begin
                res_d.valid    = 1'b1;
                res_d.log_full = 1'b1;
                state_d        = slj_pkg::ST_DONE;
              end else begin
                state_d = slj_pkg::ST_WRD;
              end
            end
            slj_pkg::CMD_READ: begin
              state_d = slj_pkg::ST_RRD;
            end
            default: begin
              // Unused command: no state change, all-zero result.
              res_d.valid = 1'b1;
              state_d     = slj_pkg::ST_DONE;
            end
          endcase
        end
      end
      slj_pkg::ST_WRD: begin
        mem_req_o.addr = wp_q[slj_pkg::ADDR_W-1:0];
        state_d        = slj_pkg::ST_WCHK;
      end
      slj_pkg::ST_WCHK: begin
        mem_req_o.addr = wp_q[slj_pkg::ADDR_W-1:0];
        if (mem_rdata_i == slj_pkg::SLOT_EMPTY) begin
          // The final slot always closes the log with the no-resume mark.
          mem_req_o.we    = 1'b1;
          mem_req_o.wdata = (wp_q == LastPtr) ? slj_pkg::NO_RESUME_MARK : byte_q;
          res_d.valid     = 1'b1;
          state_d         = slj_pkg::ST_DONE;
        end else begin
          wp_d = wp_q + 1'b1;
          if (wp_q == LastPtr) begin
            res_d.valid    = 1'b1;
            res_d.log_full = 1'b1;
            state_d        = slj_pkg::ST_DONE;
          end else begin
            state_d = slj_pkg::ST_WRD;
          end
        end
      end
      slj_pkg::ST_RRD: begin
        state_d = slj_pkg::ST_RCHK;
      end
      slj_pkg::ST_RCHK: begin
        if (mem_rdata_i == slj_pkg::SLOT_EMPTY || scan_q == LastAddr) begin
          if (mem_rdata_i != slj_pkg::SLOT_EMPTY) begin
            last_d = mem_rdata_i;
            any_d  = 1'b1;
          end
          res_d.valid = 1'b1;
          if (any_d && last_d != slj_pkg::NO_RESUME_MARK) begin
            res_d.resume_valid = 1'b1;
            res_d.resume_state = last_d;
          end
          state_d = slj_pkg::ST_DONE;
        end else begin
          last_d  = mem_rdata_i;
          any_d   = 1'b1;
          scan_d  = scan_q + 1'b1;
          state_d = slj_pkg::ST_RRD;
        end
      end
      slj_pkg::ST_DONE: begin
        if (result_take_i) begin
          res_d.valid = 1'b0;
          state_d     = slj_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = slj_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= slj_pkg::ST_CLEAR;
      wp_q    <= '0;
      scan_q  <= '0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      wp_q    <= wp_d;
      scan_q  <= scan_d;
      res_q   <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
    any_q  <= any_d;
  end

endmodule

### hw/rtl/slot_journal_state_log_unit.sv
// Slot journal state log: one result item per command, resume lookup and append over a slot RAM.
// A write scans slots from the write pointer and a read scans from slot 0, each slot through a
// read state and a check state; a write to an exhausted log or an unused command goes straight
// to the result without a scan.
// Each slot check is a read and a compare through the one port of the slot RAM.
// Throughput: one item at a time; the next item is accepted the cycle after the result enters
// the output register. Reset: a clearing pass writes every slot empty, with in_stall_o high
// throughout.
module slot_journal_state_log_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] in_command_i,
  input  logic [7:0] in_state_value_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       out_resume_valid_o,
  output logic [7:0] out_resume_state_o,
  output logic       out_log_full_o
);

  slj_pkg::mem_req_t mem_req;
  logic [7:0]        mem_rdata;
  slj_pkg::result_t  result;
  logic              take;
  logic              out_valid_q, out_valid_d;
  logic              resume_valid_q;
  logic [7:0]        resume_state_q;
  logic              log_full_q;

  slj_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (in_command_i),
    .state_value_i (in_state_value_i),
    .mem_req_o     (mem_req),
    .mem_rdata_i   (mem_rdata),
    .result_o      (result),
    .result_take_i (take)
  );

  slj_ram #(
    .Width (8),
    .Depth (slj_pkg::NUM_SLOTS)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .addr_i  (mem_req.addr),
    .wdata_i (mem_req.wdata),
    .rdata_o (mem_rdata)
  );

  // The output register takes a new result whenever it is empty or being drained.
  assign take        = result.valid && (!out_valid_q || !out_stall_i);
  assign out_valid_d = take || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      resume_valid_q <= result.resume_valid;
      resume_state_q <= result.resume_state;
      log_full_q     <= result.log_full;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_resume_valid_o = resume_valid_q;
  assign out_resume_state_o = resume_state_q;
  assign out_log_full_o     = log_full_q;

  a_full_excludes_resume: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_resume_valid_o && out_log_full_o))
    else $error("result flags both a resume state and a full log");

  a_no_resume_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_resume_valid_o) |-> (out_resume_state_o == 8'h00))
    else $error("resume state is not zero without a resumable state");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled while an item is being processed");

endmodule

### verif/tb_slot_journal_state_log_unit.sv
// Self-checking testbench for the slot journal state log unit.
`timescale 1ns / 100ps

module tb_slot_journal_state_log_unit;
  import slj_pkg::*;

  // Command code 3 has no member in cmd_e; the block must answer it with all zeros.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int SCAN_LATENCY = 2 * NUM_SLOTS + 3;
  localparam int RANDOM_ITEMS = 500;
  localparam int PHASE_ITEMS  = 50;

  typedef struct packed {
    bit       resume_valid;
    bit [7:0] resume_state;
    bit       log_full;
  } journal_result_t;

  class journal_tracker;
    logic [7:0]      slots[NUM_SLOTS];
    int              wr_ptr;
    journal_result_t pending_results[$];
    int              mismatches;
    int              results_seen;
    int              writes_sent;
    int              writes_dropped;
    int              reads_sent;
    int              resumes_found;

    function new();
      foreach (slots[i]) slots[i] = SLOT_EMPTY;
      wr_ptr = 0;
    endfunction

    // The pointer only moves past filled slots, so a stored 0xFF is reused by the next write.
    function bit append_slot(logic [7:0] value);
      writes_sent++;
      while (wr_ptr < NUM_SLOTS && slots[wr_ptr] != SLOT_EMPTY) wr_ptr++;
      if (wr_ptr >= NUM_SLOTS) begin
        writes_dropped++;
        return 1'b1;
      end
      slots[wr_ptr] = (wr_ptr == NUM_SLOTS - 1) ? NO_RESUME_MARK : value;
      return 1'b0;
    endfunction

    function journal_result_t find_resume();
      journal_result_t res;
      logic [7:0]      last_val;
      bit              found;
      res = '0;
      last_val = SLOT_EMPTY;
      found = 1'b0;
      reads_sent++;
      for (int i = 0; i < NUM_SLOTS && slots[i] != SLOT_EMPTY; i++) begin
        last_val = slots[i];
        found = 1'b1;
      end
      if (found && last_val != NO_RESUME_MARK) begin
        res.resume_valid = 1'b1;
        res.resume_state = last_val;
        resumes_found++;
      end
      return res;
    endfunction

    function void log_command(logic [1:0] cmd, logic [7:0] value);
      journal_result_t res;
      res = '0;
      case (cmd)
        CMD_WRITE: res.log_full = append_slot(value);
        CMD_MARK:  res.log_full = append_slot(NO_RESUME_MARK);
        CMD_READ:  res = find_resume();
        default: ;
      endcase
      pending_results.push_back(res);
    endfunction

    function void compare_result(logic rv, logic [7:0] rs, logic lf);
      journal_result_t want;
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d arrived with nothing outstanding: rv=%0d rs=%02h full=%0d",
                   results_seen, rv, rs, lf);
        return;
      end
      want = pending_results.pop_front();
      if (rv !== want.resume_valid || rs !== want.resume_state || lf !== want.log_full) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: expected rv=%0d rs=%02h full=%0d, got rv=%0d rs=%02h full=%0d",
                   results_seen, want.resume_valid, want.resume_state, want.log_full,
                   rv, rs, lf);
      end
    endfunction
  endclass

  logic       clk_i              = 1'b0;
  logic       rst_ni             = 1'b0;
  logic       in_valid_i         = 1'b0;
  logic       in_stall_o;
  logic [1:0] in_command_i       = CMD_WRITE;
  logic [7:0] in_state_value_i   = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i        = 1'b0;
  logic       out_resume_valid_o;
  logic [7:0] out_resume_state_o;
  logic       out_log_full_o;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  journal_tracker tracker = new();

  slot_journal_state_log_unit uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .in_command_i       (in_command_i),
    .in_state_value_i   (in_state_value_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_resume_valid_o (out_resume_valid_o),
    .out_resume_state_o (out_resume_state_o),
    .out_log_full_o     (out_log_full_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Results are sampled with the stall value that was in force at this edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0)
      tracker.compare_result(out_resume_valid_o, out_resume_state_o, out_log_full_o);
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic send_command(input logic [1:0] cmd, input logic [7:0] value);
    int gap;
    in_valid_i       <= 1'b1;
    in_command_i     <= cmd;
    in_state_value_i <= value;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    tracker.log_command(cmd, value);
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin
    logic [1:0] cmd;
    logic [7:0] value;
    int         pick;
    int         phase;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty log, unused code, 0xFF reuse, completion marker, field extremes.
    send_command(CMD_READ, 8'h00);
    send_command(CMD_UNUSED, 8'hFF);
    send_command(CMD_WRITE, 8'h00);
    send_command(CMD_READ, 8'hFF);
    send_command(CMD_WRITE, SLOT_EMPTY);
    send_command(CMD_READ, 8'h00);
    send_command(CMD_WRITE, 8'hFE);
    send_command(CMD_READ, 8'h00);
    send_command(CMD_MARK, 8'h5A);
    send_command(CMD_READ, 8'h00);
    send_command(CMD_WRITE, 8'h01);
    send_command(CMD_READ, 8'h00);
    send_command(CMD_WRITE, NO_RESUME_MARK);
    send_command(CMD_READ, 8'h00);
    send_command(CMD_WRITE, 8'h80);
    send_command(CMD_WRITE, 8'h7F);
    send_command(CMD_READ, 8'h00);
    send_command(CMD_UNUSED, 8'h00);

    // Random: writes are rare enough that the log fills past the midpoint, so the
    // last-slot marker and the exhausted log both get a long run of reads and writes.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      phase = (n / PHASE_ITEMS) % 4;
      send_idle_pct  = (phase == 1) ? 60 : (phase == 3) ? 21 : 0;
      recv_stall_pct = (phase == 2) ? 60 : (phase == 3) ? 21 : 0;
      pick  = $urandom_range(99);
      value = $urandom_range(255);
      if (pick < 18) begin
        cmd = CMD_WRITE;
        if ($urandom_range(7) == 0) value = SLOT_EMPTY;
      end else if (pick < 22) begin
        cmd = CMD_MARK;
      end else if (pick < 94) begin
        cmd = CMD_READ;
      end else begin
        cmd = CMD_UNUSED;
      end
      send_command(cmd, value);
    end
    in_valid_i <= 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;

    while (tracker.pending_results.size() != 0) @(posedge clk_i);
    repeat (SCAN_LATENCY) @(posedge clk_i);

    $display("Checked %0d results: %0d writes (%0d dropped on a full log), %0d reads.",
             tracker.results_seen, tracker.writes_sent, tracker.writes_dropped,
             tracker.reads_sent);
    $display("Reads that found a resumable state: %0d; mismatches counted: %0d.",
             tracker.resumes_found, tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
      $display("slot_journal_state_log_unit: match");
    end else begin
      $display("slot_journal_state_log_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Run did not finish in time.");
    $display("slot_journal_state_log_unit: mismatch");
    $finish;
  end

endmodule
